[sv/wvbm_pkg.sv]
// Package for the wavetable voice bank mixer: widths, command and state codes,
// the voice record and the quarter-wave sine table built at elaboration.
// No dependencies.
package wvbm_pkg;

  // Sizes
  localparam int VOICES     = 16;
  localparam int TABLE_SIZE = 1024;
  localparam int ADDR_W     = $clog2(VOICES);
  localparam int COUNT_W    = $clog2(VOICES + 1);
  localparam int TBL_W      = $clog2(TABLE_SIZE);
  localparam int QTR_SIZE   = TABLE_SIZE / 4;
  localparam int QTR_W      = TBL_W - 2;
  localparam int FRAC_W     = 16;
  localparam int PHASE_W    = TBL_W + FRAC_W;
  localparam int AMP_W      = 16;
  localparam int DECAY_W    = 16;
  localparam int SINE_W     = 16;
  localparam int CMD_W      = 3;
  localparam int INDEX_W    = 4;
  localparam int SAMPLE_W   = 36;
  localparam int PROD_W     = AMP_W + SINE_W + 1;
  localparam int ACC_W      = (PROD_W + ADDR_W + 1 > SAMPLE_W + 1) ?
                              (PROD_W + ADDR_W + 1) : (SAMPLE_W + 1);

  localparam logic [AMP_W-1:0] FLOOR_RESET = AMP_W'(2);
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] QSINE_MAX = 64'd32767;

  // Sample range limits at accumulator width
  localparam logic signed [ACC_W-1:0] ACC_HI = ACC_W'({1'b0, {(SAMPLE_W-1){1'b1}}});
  localparam logic signed [ACC_W-1:0] ACC_LO = ~ACC_HI;

  // Commands
  typedef enum logic [CMD_W-1:0] {
    CMD_TICK     = 3'd0,
    CMD_ADD      = 3'd1,
    CMD_SET_STEP = 3'd2,
    CMD_SET_AMP  = 3'd3,
    CMD_CLEAR    = 3'd4,
    CMD_PRUNE    = 3'd5
  } cmd_t;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DONE
  } state_t;

  // One voice as stored in the voice memory
  typedef struct packed {
    logic [PHASE_W-1:0] step;
    logic [AMP_W-1:0]   amp;
    logic [PHASE_W-1:0] phase;
    logic [DECAY_W-1:0] decay;
  } voice_t;

  typedef logic [QTR_SIZE-1:0][SINE_W-1:0] qsine_tab_t;

  // Two Q30 multiplies of the running Taylor term by x
  function automatic logic [63:0] term_step(input logic [63:0] t, input logic [63:0] x);
    logic [63:0] a;
    a = (t * x) >> 30;
    return (a * x) >> 30;
  endfunction

  // sin(r * pi/2 / QTR_SIZE) in Q15, Taylor series to x^13
  function automatic logic [SINE_W-1:0] quarter_sine(input logic [63:0] r);
    logic [63:0]        x;
    logic [63:0]        t;
    logic signed [63:0] s;
    logic [63:0]        q;
    x = (r * HALF_PI_Q30) / QTR_SIZE;
    t = x;
    s = $signed(x);
    t = term_step(t, x) / 64'd6;
    s = s - $signed(t);
    t = term_step(t, x) / 64'd20;
    s = s + $signed(t);
    t = term_step(t, x) / 64'd42;
    s = s - $signed(t);
    t = term_step(t, x) / 64'd72;
    s = s + $signed(t);
    t = term_step(t, x) / 64'd110;
    s = s - $signed(t);
    t = term_step(t, x) / 64'd156;
    s = s + $signed(t);
    if (s < 0) begin
      s = 64'sd0;
    end
    q = ($unsigned(s) + 64'd16384) >> 15;
    if (q > QSINE_MAX) begin
      q = QSINE_MAX;
    end
    return q[SINE_W-1:0];
  endfunction

  // Entry j holds the quarter sine at step j+1 (step zero is zero)
  function automatic qsine_tab_t build_qsine();
    qsine_tab_t tab;
    for (int j = 0; j < QTR_SIZE; j++) begin
      tab[j] = quarter_sine(64'(j + 1));
    end
    return tab;
  endfunction

  localparam qsine_tab_t QSINE = build_qsine();

endpackage

[sv/wvbm_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module wvbm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/wavetable_voice_bank_mixer.sv]
// Wavetable voice bank mixer top level: sequencer, voice memory and mix pipeline.
// Depends on wvbm_pkg and wvbm_ram.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid, in_stall, command, voice_index, | into block
//          | phase_step, amplitude, decay_rate         |
//  out     | out_valid, out_stall, sample,             | out of block
//          | voice_count, add_dropped                  |
//  cfg     | cfg_valid, cfg_ready, cfg_data            | into block
//
// One item at a time. For a tick, the voice memory is read one voice a cycle, then
// the sine lookup, multiply and accumulate stages drain before the result loads.
// Prune reads every voice the same way, a set command reads and rewrites its voice
// (nothing for an ignored index), and the rest go straight to the result. The next
// item is taken the cycle after the result loads.
// Reset empties the voice list and sets the amplitude floor to 2.
// A finished result waits in the output register while out_stall is high;
// the next item is taken meanwhile and waits only at its own completion.
module wavetable_voice_bank_mixer
  import wvbm_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [CMD_W-1:0]           command,
  input  logic [INDEX_W-1:0]         voice_index,
  input  logic [PHASE_W-1:0]         phase_step,
  input  logic [AMP_W-1:0]           amplitude,
  input  logic [DECAY_W-1:0]         decay_rate,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [SAMPLE_W-1:0] sample,
  output logic [COUNT_W-1:0]         voice_count,
  output logic                       add_dropped,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [AMP_W-1:0]           cfg_data
);

  state_t state, state_next;

  logic [AMP_W-1:0]   amp_floor;
  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] rd_idx;
  logic [COUNT_W-1:0] rd_end;
  logic [COUNT_W-1:0] keep;
  logic               dropped;
  cmd_t               cmd_q;
  logic [PHASE_W-1:0] step_q;
  logic [AMP_W-1:0]   amp_in_q;

  logic               p1_valid;
  logic [ADDR_W-1:0]  p1_addr;
  logic               p2_valid;
  logic [AMP_W-1:0]   p2_amp;
  logic signed [SINE_W-1:0] p2_sine;
  logic               p3_valid;
  logic signed [PROD_W-1:0] p3_prod;
  logic signed [ACC_W-1:0]  acc;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  voice_t             ram_wdata;
  logic [ADDR_W-1:0]  ram_raddr;
  voice_t             ram_rdata;

  logic               accept;
  logic               issue;
  logic               run_done;
  logic               out_free;
  logic               load_out;
  logic               idx_ok;
  logic               add_ok;
  logic [COUNT_W-1:0] idx_ext;

  logic [TBL_W-1:0]   pos;
  logic [QTR_W:0]     qidx;
  logic [SINE_W-1:0]  mag;
  logic signed [SINE_W-1:0] sine_val;
  logic [PHASE_W-1:0] phase_adv;
  logic [DECAY_W:0]   keep_frac;
  logic [AMP_W+DECAY_W:0] amp_scaled;
  logic [AMP_W-1:0]   amp_decayed;
  logic signed [SAMPLE_W-1:0] sample_sat;

  wvbm_ram #(
    .WIDTH($bits(voice_t)),
    .DEPTH(VOICES)
  ) u_voice_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Handshake helpers
  assign cfg_ready = 1'b1;
  assign idx_ext   = COUNT_W'(voice_index);
  assign idx_ok    = idx_ext < count;
  assign add_ok    = count < COUNT_W'(VOICES);
  assign issue     = (state == S_RUN) && (rd_idx != rd_end);
  assign run_done  = (rd_idx == rd_end) && !p1_valid && !p2_valid && !p3_valid;
  assign out_free  = !out_valid || !out_stall;

  // Sine lookup from the quarter-wave table
  always_comb begin
    pos  = ram_rdata.phase[PHASE_W-1 -: TBL_W];
    qidx = pos[TBL_W-2] ? ((QTR_W+1)'(QTR_SIZE) - {1'b0, pos[QTR_W-1:0]})
                        : {1'b0, pos[QTR_W-1:0]};
    if (qidx == '0) begin
      mag = '0;
    end else begin
      mag = QSINE[QTR_W'(qidx - 1'b1)];
    end
    sine_val = pos[TBL_W-1] ? -$signed(mag) : $signed(mag);
  end

  // Phase advance and amplitude decay of the voice just read
  always_comb begin
    phase_adv   = ram_rdata.phase + ram_rdata.step;
    keep_frac   = (DECAY_W+1)'(1 << DECAY_W) - {1'b0, ram_rdata.decay};
    amp_scaled  = (AMP_W+DECAY_W+1)'(ram_rdata.amp) * (AMP_W+DECAY_W+1)'(keep_frac);
    amp_decayed = amp_scaled[AMP_W+DECAY_W-1 -: AMP_W];
  end

  // Saturate the mix to the sample range
  always_comb begin
    if (acc > ACC_HI) begin
      sample_sat = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end else if (acc < ACC_LO) begin
      sample_sat = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      sample_sat = acc[SAMPLE_W-1:0];
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          case (command)
            CMD_TICK, CMD_PRUNE:       state_next = S_RUN;
            CMD_SET_STEP, CMD_SET_AMP: state_next = idx_ok ? S_RUN : S_DONE;
            default:                   state_next = S_DONE;
          endcase
        end
      end
      S_RUN: begin
        if (run_done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control outputs and memory ports
  always_comb begin
    in_stall  = (state != S_IDLE);
    accept    = (state == S_IDLE) && in_valid;
    load_out  = (state == S_DONE) && out_free;
    ram_raddr = rd_idx[ADDR_W-1:0];
    ram_we    = 1'b0;
    ram_waddr = p1_addr;
    ram_wdata = ram_rdata;
    if (accept && (command == CMD_ADD) && add_ok) begin
      // Append a new voice at the end of the list
      ram_we          = 1'b1;
      ram_waddr       = count[ADDR_W-1:0];
      ram_wdata.step  = phase_step;
      ram_wdata.amp   = amplitude;
      ram_wdata.phase = '0;
      ram_wdata.decay = decay_rate;
    end else if (p1_valid) begin
      case (cmd_q)
        CMD_TICK: begin
          ram_we          = 1'b1;
          ram_wdata.amp   = amp_decayed;
          ram_wdata.phase = phase_adv;
        end
        CMD_PRUNE: begin
          ram_we    = ram_rdata.amp >= amp_floor;
          ram_waddr = keep[ADDR_W-1:0];
        end
        CMD_SET_STEP: begin
          ram_we         = 1'b1;
          ram_wdata.step = step_q;
        end
        CMD_SET_AMP: begin
          ram_we        = 1'b1;
          ram_wdata.amp = amp_in_q;
        end
        default: ram_we = 1'b0;
      endcase
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      amp_floor <= FLOOR_RESET;
      count     <= '0;
      rd_idx    <= '0;
      rd_end    <= '0;
      p1_valid  <= 1'b0;
      p2_valid  <= 1'b0;
      p3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      p1_valid <= issue;
      p2_valid <= p1_valid && (cmd_q == CMD_TICK);
      p3_valid <= p2_valid;
      if (cfg_valid && cfg_ready) begin
        amp_floor <= cfg_data;
      end
      if (issue) begin
        rd_idx <= rd_idx + 1'b1;
      end
      // Start the read sweep and apply single-step commands
      if (accept) begin
        case (command)
          CMD_TICK, CMD_PRUNE: begin
            rd_idx <= '0;
            rd_end <= count;
          end
          CMD_SET_STEP, CMD_SET_AMP: begin
            rd_idx <= idx_ext;
            rd_end <= idx_ext + 1'b1;
          end
          CMD_ADD: begin
            if (add_ok) begin
              count <= count + 1'b1;
            end
          end
          CMD_CLEAR: count <= '0;
          default: count <= count;
        endcase
      end
      // Prune ends with the kept voices
      if ((state == S_RUN) && run_done && (cmd_q == CMD_PRUNE)) begin
        count <= keep;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    p1_addr <= rd_idx[ADDR_W-1:0];
    p2_amp  <= ram_rdata.amp;
    p2_sine <= sine_val;
    p3_prod <= PROD_W'($signed({1'b0, p2_amp})) * PROD_W'(p2_sine);
    if (accept) begin
      cmd_q    <= cmd_t'(command);
      step_q   <= phase_step;
      amp_in_q <= amplitude;
      dropped  <= (command == CMD_ADD) && !add_ok;
      acc      <= '0;
      keep     <= '0;
    end else begin
      if (p3_valid) begin
        acc <= acc + ACC_W'(p3_prod);
      end
      if (p1_valid && (cmd_q == CMD_PRUNE) && (ram_rdata.amp >= amp_floor)) begin
        keep <= keep + 1'b1;
      end
    end
    // Hold the result until taken
    if (load_out) begin
      sample      <= (cmd_q == CMD_TICK) ? sample_sat : '0;
      voice_count <= count;
      add_dropped <= dropped;
    end
  end

endmodule

[dv/wvbm_mix_checker.sv]
// Checker for the wavetable voice bank mixer. It watches the item, result and
// floor-write channels, predicts every result and compares it field by field.
// Depends on wvbm_pkg for widths, command codes and the Q30 half-pi constant.
module wvbm_mix_checker
  import wvbm_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic [CMD_W-1:0]           command,
  input  logic [INDEX_W-1:0]         voice_index,
  input  logic [PHASE_W-1:0]         phase_step,
  input  logic [AMP_W-1:0]           amplitude,
  input  logic [DECAY_W-1:0]         decay_rate,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic [COUNT_W-1:0]         voice_count,
  input  logic                       add_dropped,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [AMP_W-1:0]           cfg_data,
  output int                         outstanding,
  output int                         fail_count
);

  typedef struct packed {
    logic [SAMPLE_W-1:0] mix;
    logic [COUNT_W-1:0]  count;
    logic                dropped;
  } mix_result_t;

  localparam longint MIX_HI = (64'sd1 <<< (SAMPLE_W - 1)) - 64'sd1;
  localparam longint MIX_LO = -(64'sd1 <<< (SAMPLE_W - 1));

  logic signed [SINE_W-1:0] sine_tab [TABLE_SIZE];
  logic [PHASE_W-1:0]       step_mem [VOICES];
  logic [AMP_W-1:0]         amp_mem [VOICES];
  logic [PHASE_W-1:0]       phase_mem [VOICES];
  logic [DECAY_W-1:0]       decay_mem [VOICES];
  int unsigned              live;
  logic [AMP_W-1:0]         floor_q;
  mix_result_t              due_results [$];
  mix_result_t              want;
  int                       errors = 0;

  // Full-wave sine entry in Q1.15: fold into the first quadrant, Taylor to x^13
  function automatic logic signed [SINE_W-1:0] sine_at(input int unsigned k);
    longint unsigned a;
    longint unsigned quad;
    longint unsigned r;
    longint unsigned x;
    longint unsigned term;
    longint unsigned mag;
    longint          acc;
    a    = 4 * k;
    quad = a / TABLE_SIZE;
    r    = a % TABLE_SIZE;
    if (quad[0]) begin
      r = TABLE_SIZE - r;
    end
    x    = (r * HALF_PI_Q30) / TABLE_SIZE;
    term = x;
    acc  = longint'(x);
    for (int n = 1; n <= 6; n++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = term / ((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    mag = (longint'(acc) + 16384) >> 15;
    if (mag > 32767) begin
      mag = 32767;
    end
    return (quad >= 2) ? -SINE_W'(mag) : SINE_W'(mag);
  endfunction

  initial begin
    for (int k = 0; k < TABLE_SIZE; k++) begin
      sine_tab[k] = sine_at(k);
    end
  end

  // Apply one command to the voice list and return the result it produces
  function automatic mix_result_t advance_voice_bank(input logic [CMD_W-1:0] cmd,
                                                     input logic [INDEX_W-1:0] idx,
                                                     input logic [PHASE_W-1:0] step,
                                                     input logic [AMP_W-1:0] amp,
                                                     input logic [DECAY_W-1:0] dec);
    mix_result_t res;
    longint      acc;
    int unsigned kept;
    int unsigned scaled;
    res = '0;
    acc = 0;
    case (cmd)
      CMD_TICK: begin
        for (int v = 0; v < live; v++) begin
          acc = acc + longint'(amp_mem[v]) *
                      longint'(sine_tab[phase_mem[v][PHASE_W-1:FRAC_W]]);
          phase_mem[v] = phase_mem[v] + step_mem[v];
          scaled = amp_mem[v] * (32'd65536 - decay_mem[v]);
          amp_mem[v] = scaled[31:16];
        end
        if (acc > MIX_HI) begin
          acc = MIX_HI;
        end
        if (acc < MIX_LO) begin
          acc = MIX_LO;
        end
        res.mix = acc[SAMPLE_W-1:0];
      end
      CMD_ADD: begin
        if (live < VOICES) begin
          step_mem[live]  = step;
          amp_mem[live]   = amp;
          phase_mem[live] = '0;
          decay_mem[live] = dec;
          live++;
        end else begin
          res.dropped = 1'b1;
        end
      end
      CMD_SET_STEP: begin
        if (idx < live) begin
          step_mem[idx] = step;
        end
      end
      CMD_SET_AMP: begin
        if (idx < live) begin
          amp_mem[idx] = amp;
        end
      end
      CMD_CLEAR: begin
        live = 0;
      end
      CMD_PRUNE: begin
        kept = 0;
        for (int v = 0; v < live; v++) begin
          if (amp_mem[v] >= floor_q) begin
            step_mem[kept]  = step_mem[v];
            amp_mem[kept]   = amp_mem[v];
            phase_mem[kept] = phase_mem[v];
            decay_mem[kept] = decay_mem[v];
            kept++;
          end
        end
        live = kept;
      end
      default: begin
      end
    endcase
    res.count = COUNT_W'(live);
    return res;
  endfunction

  // Check results first: a result can never belong to an item taken at the same edge
  always @(posedge clk) begin
    if (rst) begin
      live    = 0;
      floor_q = FLOOR_RESET;
      due_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          $error("result with no item waiting: sample %0d, voice_count %0d",
                 sample, voice_count);
          errors++;
        end else begin
          want = due_results.pop_front();
          if (sample !== $signed(want.mix)) begin
            $error("sample: expected %0d, got %0d", $signed(want.mix), sample);
            errors++;
          end
          if (voice_count !== want.count) begin
            $error("voice_count: expected %0d, got %0d", want.count, voice_count);
            errors++;
          end
          if (add_dropped !== want.dropped) begin
            $error("add_dropped: expected %0d, got %0d", want.dropped, add_dropped);
            errors++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        floor_q = cfg_data;
      end
      if (in_valid && !in_stall) begin
        due_results.push_back(advance_voice_bank(command, voice_index, phase_step,
                                                 amplitude, decay_rate));
      end
    end
    outstanding <= due_results.size();
    fail_count  <= errors;
  end

endmodule

[dv/testbench.sv]
// Top of the mixer testbench: clock, reset, item and floor-write stimulus,
// random idling on both channels, and the verdict.
// Depends on wvbm_pkg, wavetable_voice_bank_mixer and wvbm_mix_checker.
module testbench;
  import wvbm_pkg::*;

  // Command codes the block has no use for
  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;
  localparam logic [PHASE_W-1:0] STEP_MAX = '1;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [CMD_W-1:0]           command = CMD_TICK;
  logic [INDEX_W-1:0]         voice_index = '0;
  logic [PHASE_W-1:0]         phase_step = '0;
  logic [AMP_W-1:0]           amplitude = '0;
  logic [DECAY_W-1:0]         decay_rate = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [SAMPLE_W-1:0] sample;
  logic [COUNT_W-1:0]         voice_count;
  logic                       add_dropped;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [AMP_W-1:0]           cfg_data = '0;
  logic                       calm = 1'b0;
  int                         outstanding;
  int                         fail_count;

  wavetable_voice_bank_mixer u_top (.*);

  wvbm_mix_checker u_check (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stall the result side at random, except in the calm phase
  always @(posedge clk) begin
    out_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 28);
  end

  // Hard stop well past the slowest correct run
  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // Offer one item after a random gap and hold it until it is taken
  task automatic issue(input logic [CMD_W-1:0] cmd, input logic [INDEX_W-1:0] idx,
                       input logic [PHASE_W-1:0] step, input logic [AMP_W-1:0] amp,
                       input logic [DECAY_W-1:0] dec);
    while (!calm && $urandom_range(0, 99) < 28) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    command     <= cmd;
    voice_index <= idx;
    phase_step  <= step;
    amplitude   <= amp;
    decay_rate  <= dec;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
  endtask

  // Drop valid and wait until every predicted result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic set_amplitude_floor(input logic [AMP_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int                 taken;
    int                 pick;
    logic [CMD_W-1:0]   cmd;
    logic [INDEX_W-1:0] idx;
    logic [PHASE_W-1:0] step;
    logic [AMP_W-1:0]   amp;
    logic [DECAY_W-1:0] dec;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty list, extremes, ignored indexes, spare command, prune, full list
    issue(CMD_TICK, 4'd0, '0, '0, '0);
    issue(CMD_SET_STEP, 4'd0, STEP_MAX, '0, '0);
    issue(CMD_ADD, 4'd0, STEP_MAX, 16'hFFFF, 16'h0000);
    issue(CMD_ADD, 4'd0, '0, 16'h0000, 16'hFFFF);
    issue(CMD_ADD, 4'd0, PHASE_W'(32'h1_0000), 16'h8000, 16'h8000);
    issue(CMD_TICK, 4'd0, '0, '0, '0);
    issue(CMD_TICK, 4'd0, '0, '0, '0);
    issue(CMD_SET_STEP, 4'd0, PHASE_W'(32'h100_0000), '0, '0);
    issue(CMD_SET_AMP, 4'd1, '0, 16'd1, '0);
    issue(CMD_SET_AMP, 4'd9, '0, 16'hFFFF, '0);
    issue(CMD_SPARE_LO, 4'd15, STEP_MAX, 16'hFFFF, 16'hFFFF);
    issue(CMD_TICK, 4'd0, '0, '0, '0);
    issue(CMD_PRUNE, 4'd0, '0, '0, '0);
    for (int v = 0; v < VOICES - 2; v++) begin
      issue(CMD_ADD, 4'd0, PHASE_W'($urandom), 16'hFFFF, 16'h0000);
    end
    issue(CMD_ADD, 4'd0, STEP_MAX, 16'hFFFF, 16'hFFFF);
    issue(CMD_TICK, 4'd0, '0, '0, '0);
    issue(CMD_CLEAR, 4'd0, '0, '0, '0);

    // Random phases, each with its own amplitude floor
    for (int p = 0; p < 6; p++) begin
      drain_results();
      case (p)
        1: set_amplitude_floor(16'h0000);
        2: set_amplitude_floor(16'hFFFF);
        3: set_amplitude_floor(16'h4000);
        4: set_amplitude_floor(AMP_W'($urandom));
        5: set_amplitude_floor(16'd1);
        default: begin
        end
      endcase
      calm  <= (p == 2);
      taken = 0;
      while (taken < 185) begin
        pick = $urandom_range(0, 99);
        if (pick < 35 || (pick >= 92 && pick < 98)) begin
          cmd = CMD_TICK;
        end else if (pick < 57) begin
          cmd = CMD_ADD;
        end else if (pick < 67) begin
          cmd = CMD_SET_STEP;
        end else if (pick < 77) begin
          cmd = CMD_SET_AMP;
        end else if (pick < 86) begin
          cmd = CMD_PRUNE;
        end else if (pick < 92) begin
          cmd = CMD_CLEAR;
        end else if (pick == 98) begin
          cmd = CMD_SPARE_LO;
        end else begin
          cmd = CMD_SPARE_HI;
        end
        idx = INDEX_W'($urandom_range(0, 15));
        case ($urandom_range(0, 5))
          0: step = PHASE_W'($urandom);
          1: step = ($urandom_range(0, 1) == 1) ? STEP_MAX : '0;
          default: step = PHASE_W'($urandom_range(0, 32'h0020_0000));
        endcase
        amp = ($urandom_range(0, 1) == 1) ? AMP_W'($urandom) :
                                            AMP_W'($urandom_range(0, 16'h4000));
        dec = ($urandom_range(0, 3) == 0) ? DECAY_W'($urandom) :
                                            DECAY_W'($urandom_range(0, 3000));
        issue(cmd, idx, step, amp, dec);
        if (cmd != CMD_SPARE_LO && cmd != CMD_SPARE_HI) begin
          taken++;
        end
      end
    end

    // Let the last results settle, then give the verdict
    drain_results();
    repeat (30) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
